/* src/modular_exponentiation_defines.svh */
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("modular exponentiation assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("modular exponentiation assertion failed");

`else

`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/mexp_pkg.sv */
// Types and constants of the modular exponentiation block.
package mexp_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int FIELD_W   = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'b1;

    // Register reset values.
    localparam logic [FIELD_W-1:0] MODULUS_RESET   = 32'd23;
    localparam logic [FIELD_W-1:0] GENERATOR_RESET = 32'd5;

    // Operation codes carried in tuser.
    localparam logic OP_GENERATOR = 1'b0;
    localparam logic OP_BASE      = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_DISPATCH,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

endpackage

/* src/modular_exponentiation.sv */
// Modular exponentiation by right-to-left square-and-multiply on one shared modular adder.
//
// Input channel (s_axis): tdata carries base_value in bits 31:0 and the exponent in
// bits 63:32; tuser bit 0 is the opcode (0 takes the configured generator as base,
// 1 takes base_value). Output channel (m_axis): tdata carries the 32-bit result.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 modulus,
// 1 generator); a write applies to items accepted later, and an item in work keeps
// the values it started with.
//
// One item is in work at a time; o_s_axis_tready is high only while the sequencer
// waits for work. All arithmetic runs through a single add-and-reduce unit that
// performs one modular doubling or one modular addition per cycle. A modular
// multiply doubles once per multiplier bit and adds once per set multiplier bit.
// An item runs the base reduction, one squaring per exponent bit below the top
// set bit and one multiply per set exponent bit, with a dispatch step after each
// operation, plus the accept and hand-off steps.
// A zero exponent, or a modulus below two, skips the arithmetic and goes from
// acceptance straight to the hand-off.
//
// Reset loads the modulus with 23 and the generator with 5 and empties the output
// register. A finished result waits in the output register while the receiver
// stalls; the next item is accepted meanwhile, and its result is held back until
// the previous one has been taken.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [2*mexp_pkg::FIELD_W-1:0]      i_s_axis_tdata,  // base_value, exponent
    input  logic [0:0]                          i_s_axis_tuser,  // opcode
    // Output stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mexp_pkg::FIELD_W-1:0]        o_m_axis_tdata,  // result
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mexp_pkg::FIELD_W-1:0]        i_cfg_data
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WIDTH - 1);

    // Control registers.
    t_state               r_state, n_state;
    logic                 r_phase, n_phase;
    logic                 r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]   r_modulus, n_modulus;
    logic [FIELD_W-1:0]   r_generator, n_generator;

    // Datapath registers.
    logic [WIDTH-1:0]     r_mod, n_mod;
    logic [WIDTH-1:0]     r_exp, n_exp;
    logic [WIDTH-1:0]     r_base, n_base;
    logic [WIDTH-1:0]     r_res, n_res;
    logic [WIDTH-1:0]     r_acc, n_acc;
    logic [WIDTH-1:0]     r_a, n_a;
    logic [WIDTH-1:0]     r_mplier, n_mplier;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [FIELD_W-1:0]   r_out_data, n_out_data;

    // Operands of a new item, masked to the operand width.
    logic [WIDTH-1:0]     in_mod;
    logic [WIDTH-1:0]     in_exp;
    logic [WIDTH-1:0]     in_base;

    // Shared add-and-reduce unit: acc + x, folded back below the modulus.
    logic [WIDTH-1:0]     unit_x;
    logic [WIDTH:0]       unit_sum;
    logic [WIDTH:0]       unit_diff;
    logic [WIDTH-1:0]     unit_out;
    logic                 mul_done;

    assign in_mod  = WIDTH'(r_modulus);
    assign in_exp  = WIDTH'(i_s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    assign in_base = (i_s_axis_tuser[0] == OP_BASE) ? WIDTH'(i_s_axis_tdata[FIELD_W-1:0])
                                                     : WIDTH'(r_generator);

    assign unit_x    = r_phase ? r_a : r_acc;
    assign unit_sum  = {1'b0, r_acc} + {1'b0, unit_x};
    assign unit_diff = unit_sum - {1'b0, r_mod};
    assign unit_out  = (unit_sum >= {1'b0, r_mod}) ? unit_diff[WIDTH-1:0]
                                                   : unit_sum[WIDTH-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Sequencer next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_modulus   = r_modulus;
        n_generator = r_generator;
        n_mod       = r_mod;
        n_exp       = r_exp;
        n_base      = r_base;
        n_res       = r_res;
        n_acc       = r_acc;
        n_a         = r_a;
        n_mplier    = r_mplier;
        n_cnt       = r_cnt;
        n_out_data  = r_out_data;
        mul_done    = 1'b0;

        // The output register empties when its transaction completes.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes.
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:   n_modulus   = i_cfg_data;
                REG_GENERATOR: n_generator = i_cfg_data;
                default:       ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_mod = in_mod;
                    n_exp = in_exp;
                    if (in_exp == '0) begin
                        n_res   = WIDTH'(1);
                        n_state = S_DONE;
                    end else if (in_mod <= WIDTH'(1)) begin
                        // No reduction possible, or everything reduces to zero.
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        // Reduce the base as 1 * base mod m on the shared unit.
                        n_res    = WIDTH'(1);
                        n_acc    = '0;
                        n_a      = WIDTH'(1);
                        n_mplier = in_base;
                        n_cnt    = CNT_TOP;
                        n_phase  = 1'b0;
                        n_state  = S_REDUCE;
                    end
                end
            end
            S_REDUCE, S_MUL, S_SQR: begin
                // Doubling phase, then an addition phase for a set multiplier bit.
                n_acc = unit_out;
                if (!r_phase && r_mplier[WIDTH-1]) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase  = 1'b0;
                    n_mplier = r_mplier << 1;
                    if (r_cnt == '0) begin
                        mul_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
                if (mul_done) begin
                    n_state = S_DISPATCH;
                    if (r_state == S_MUL) begin
                        n_res    = unit_out;
                        n_exp[0] = 1'b0;
                    end else if (r_state == S_SQR) begin
                        n_base = unit_out;
                        n_exp  = r_exp >> 1;
                    end else begin
                        n_base = unit_out;
                    end
                end
            end
            S_DISPATCH: begin
                // Finish on a zero exponent; else multiply in a set low exponent bit, else square the base.
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_acc   = '0;
                    n_cnt   = CNT_TOP;
                    n_phase = 1'b0;
                    n_a     = r_base;
                    if (r_exp[0]) begin
                        n_mplier = r_res;
                        n_state  = S_MUL;
                    end else begin
                        n_mplier = r_base;
                        n_state  = S_SQR;
                    end
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = FIELD_W'(r_res);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET;
            r_generator <= GENERATOR_RESET;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_modulus   <= n_modulus;
            r_generator <= n_generator;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_mod      <= n_mod;
        r_exp      <= n_exp;
        r_base     <= n_base;
        r_res      <= n_res;
        r_acc      <= n_acc;
        r_a        <= n_a;
        r_mplier   <= n_mplier;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    // The accumulator stays reduced while the shared unit runs.
    `MEXP_ASSERT_IMP(a_acc_reduced, i_clk, i_rst_n, (r_state == S_REDUCE || r_state == S_MUL || r_state == S_SQR), (r_acc < r_mod))
    // Base and partial result stay reduced between operations.
    `MEXP_ASSERT_IMP(a_operands_reduced, i_clk, i_rst_n, (r_state == S_DISPATCH), (r_base < r_mod && r_res < r_mod))
    // The addition phase only follows a set multiplier bit.
    `MEXP_ASSERT_IMP(a_add_phase_bit, i_clk, i_rst_n, r_phase, r_mplier[WIDTH-1])
    // An accepted item always leaves the idle state.
    `MEXP_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready), (r_state != S_IDLE))

endmodule
